>>> src/cpvp_pkg.sv
`default_nettype none
package cpvp_pkg;

  localparam int NUM_WHEELS = 2;
  localparam int WHEEL_W = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;
  localparam int POS_W = 32;
  localparam int PERR_W = POS_W + 1;
  localparam int PDER_W = POS_W + 2;
  localparam int SPD_W = 16;
  localparam int OUT_W = 16;
  localparam int VERR_W = 18;
  localparam int VDER_W = VERR_W + 1;
  localparam int GAIN_W = 8;
  localparam int LIM_W = 16;
  localparam int CLAMP_W = LIM_W + 2;
  localparam int MUL_A_W = PDER_W;
  localparam int PROD_W = MUL_A_W + GAIN_W + 1;
  localparam int ACC_W = PROD_W + 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POS_KP        = 3'd0,
    CFG_POS_KD        = 3'd1,
    CFG_POS_LIMIT     = 3'd2,
    CFG_VEL_KP        = 3'd3,
    CFG_VEL_KI        = 3'd4,
    CFG_VEL_KD        = 3'd5,
    CFG_VEL_LIMIT     = 3'd6,
    CFG_VEL_INT_LIMIT = 3'd7
  } cfg_index_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_P_ERR,
    S_P_DER,
    S_P_MKP,
    S_P_MKD,
    S_P_SUM,
    S_P_CLAMP,
    S_V_ERR,
    S_V_INT,
    S_V_MKP,
    S_V_MKI,
    S_V_MKD,
    S_V_SUM,
    S_V_CLAMP
  } state_t;

  typedef struct packed {
    logic mul_en;
    logic acc_load;
    logic acc_add;
  } mac_ctl_t;

  function automatic logic signed [CLAMP_W-1:0] clamp_sym(
    input logic signed [ACC_W-1:0] v,
    input logic [LIM_W-1:0] lim
  );
    logic signed [ACC_W-1:0] l;
    l = $signed(ACC_W'(lim));
    if (v > l) begin
      return CLAMP_W'(l);
    end else if (v < -l) begin
      return CLAMP_W'(-l);
    end else begin
      return CLAMP_W'(v);
    end
  endfunction

endpackage
`default_nettype wire

>>> src/cpvp_in_if.sv
`default_nettype none
interface cpvp_in_if import cpvp_pkg::*; ();
  logic valid;
  logic ready;
  logic [WHEEL_W-1:0] wheel;
  logic signed [POS_W-1:0] position_target;
  logic signed [POS_W-1:0] position_measured;
  logic signed [SPD_W-1:0] speed_measured;

  modport source (
    output valid, wheel, position_target, position_measured, speed_measured,
    input ready
  );
  modport sink (
    input valid, wheel, position_target, position_measured, speed_measured,
    output ready
  );
endinterface
`default_nettype wire

>>> src/cpvp_out_if.sv
`default_nettype none
interface cpvp_out_if import cpvp_pkg::*; ();
  logic valid;
  logic ready;
  logic [WHEEL_W-1:0] wheel_out;
  logic signed [OUT_W-1:0] velocity_target;
  logic signed [OUT_W-1:0] drive;

  modport source (
    output valid, wheel_out, velocity_target, drive,
    input ready
  );
  modport sink (
    input valid, wheel_out, velocity_target, drive,
    output ready
  );
endinterface
`default_nettype wire

>>> src/cpvp_mac.sv
`default_nettype none
module cpvp_mac
  import cpvp_pkg::*;
(
  input  wire logic                      clk,
  input  wire mac_ctl_t                  ctl,
  input  wire logic signed [MUL_A_W-1:0] a,
  input  wire logic [GAIN_W-1:0]         b,
  output logic signed [ACC_W-1:0]        acc
);

  logic signed [PROD_W-1:0] prod;
  logic signed [GAIN_W:0]   b_ext;

  assign b_ext = $signed({1'b0, b});

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= PROD_W'(a) * PROD_W'(b_ext);
    end
    if (ctl.acc_load) begin
      acc <= ACC_W'(prod);
    end else if (ctl.acc_add) begin
      acc <= acc + ACC_W'(prod);
    end
  end

endmodule
`default_nettype wire

>>> src/cascaded_position_velocity_pid_core.sv
// Cascaded position and velocity controller for the wheels of a drive.
// A request on in_ch carries one control tick for one wheel: the wheel
// number, a position target, the measured position and the measured speed.
// The block answers each request with exactly one request on out_ch that
// carries the wheel number, the clamped velocity target of the position
// stage and the clamped motor drive value of the velocity stage.
// One signed multiplier with an accumulator is shared by all five gain
// products, each product is registered before it is summed, and a small
// sequencer steps through the work. The result is valid in the output
// register as the last step ends, and in_ch is ready again in that same
// cycle. A finished result waits there while in_ch takes the next tick; a
// further result is held in the last step until out_ch takes the earlier
// one. Gains and limits are written through cfg_we, cfg_index and cfg_data,
// by the user only while the block is idle; the block does not enforce it.
// Reset returns all gains and limits to their defaults, clears the
// per-wheel error history and integrals and empties the output.
`default_nettype none
module cascaded_position_velocity_pid_core
  import cpvp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  cpvp_in_if.sink                    in_ch,
  cpvp_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  state_t state, state_next;

  logic [GAIN_W-1:0] pos_kp, pos_kd, vel_kp, vel_ki, vel_kd;
  logic [LIM_W-2:0]  pos_limit, vel_limit;
  logic [LIM_W-1:0]  vel_int_limit;

  logic signed [PERR_W-1:0] pos_prev_error [NUM_WHEELS];
  logic signed [VERR_W-1:0] vel_integral [NUM_WHEELS];
  logic signed [VERR_W-1:0] vel_prev_error [NUM_WHEELS];

  logic [WHEEL_W-1:0]       wheel;
  logic signed [POS_W-1:0]  tgt, meas;
  logic signed [SPD_W-1:0]  spd;
  logic signed [PERR_W-1:0] perr;
  logic signed [PDER_W-1:0] pder;
  logic signed [OUT_W-1:0]  vt;
  logic signed [VERR_W-1:0] verr, vint;
  logic signed [VDER_W-1:0] vder;

  logic                     out_valid;
  logic [WHEEL_W-1:0]       out_wheel;
  logic signed [OUT_W-1:0]  out_vt, out_drive;

  mac_ctl_t                 mac_ctl;
  logic signed [MUL_A_W-1:0] mul_a;
  logic [GAIN_W-1:0]        mul_b;
  logic signed [ACC_W-1:0]  acc;

  logic in_take;
  logic out_free;

  assign in_take  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid || out_ch.ready;

  cpvp_mac u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .a   (mul_a),
    .b   (mul_b),
    .acc (acc)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (in_ch.valid) state_next = S_P_ERR;
      S_P_ERR:   state_next = S_P_DER;
      S_P_DER:   state_next = S_P_MKP;
      S_P_MKP:   state_next = S_P_MKD;
      S_P_MKD:   state_next = S_P_SUM;
      S_P_SUM:   state_next = S_P_CLAMP;
      S_P_CLAMP: state_next = S_V_ERR;
      S_V_ERR:   state_next = S_V_INT;
      S_V_INT:   state_next = S_V_MKP;
      S_V_MKP:   state_next = S_V_MKI;
      S_V_MKI:   state_next = S_V_MKD;
      S_V_MKD:   state_next = S_V_SUM;
      S_V_SUM:   state_next = S_V_CLAMP;
      S_V_CLAMP: if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    mac_ctl     = '0;
    mul_a       = MUL_A_W'(perr);
    mul_b       = pos_kp;
    unique case (state)
      S_IDLE: begin
        in_ch.ready = 1'b1;
      end
      S_P_MKP: begin
        mac_ctl.mul_en = 1'b1;
      end
      S_P_MKD: begin
        mac_ctl.mul_en   = 1'b1;
        mac_ctl.acc_load = 1'b1;
        mul_a            = pder;
        mul_b            = pos_kd;
      end
      S_P_SUM: begin
        mac_ctl.acc_add = 1'b1;
      end
      S_V_MKP: begin
        mac_ctl.mul_en = 1'b1;
        mul_a          = MUL_A_W'(verr);
        mul_b          = vel_kp;
      end
      S_V_MKI: begin
        mac_ctl.mul_en   = 1'b1;
        mac_ctl.acc_load = 1'b1;
        mul_a            = MUL_A_W'(vint);
        mul_b            = vel_ki;
      end
      S_V_MKD: begin
        mac_ctl.mul_en  = 1'b1;
        mac_ctl.acc_add = 1'b1;
        mul_a           = MUL_A_W'(vder);
        mul_b           = vel_kd;
      end
      S_V_SUM: begin
        mac_ctl.acc_add = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_kp        <= GAIN_W'(1);
      pos_kd        <= GAIN_W'(0);
      pos_limit     <= (LIM_W-1)'(30);
      vel_kp        <= GAIN_W'(50);
      vel_ki        <= GAIN_W'(5);
      vel_kd        <= GAIN_W'(1);
      vel_limit     <= (LIM_W-1)'(2000);
      vel_int_limit <= LIM_W'(100);
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_POS_KP:        pos_kp        <= cfg_data[GAIN_W-1:0];
        CFG_POS_KD:        pos_kd        <= cfg_data[GAIN_W-1:0];
        CFG_POS_LIMIT:     pos_limit     <= cfg_data[LIM_W-2:0];
        CFG_VEL_KP:        vel_kp        <= cfg_data[GAIN_W-1:0];
        CFG_VEL_KI:        vel_ki        <= cfg_data[GAIN_W-1:0];
        CFG_VEL_KD:        vel_kd        <= cfg_data[GAIN_W-1:0];
        CFG_VEL_LIMIT:     vel_limit     <= cfg_data[LIM_W-2:0];
        CFG_VEL_INT_LIMIT: vel_int_limit <= cfg_data[LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        pos_prev_error[i] <= '0;
        vel_integral[i]   <= '0;
        vel_prev_error[i] <= '0;
      end
    end else begin
      unique case (state)
        S_P_DER: pos_prev_error[wheel] <= perr;
        S_V_INT: vel_prev_error[wheel] <= verr;
        S_V_MKP: vel_integral[wheel]   <= vint;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      wheel <= in_ch.wheel;
      tgt   <= in_ch.position_target;
      meas  <= in_ch.position_measured;
      spd   <= in_ch.speed_measured;
    end
    unique case (state)
      S_P_ERR: perr <= PERR_W'(tgt) - PERR_W'(meas);
      S_P_DER: pder <= PDER_W'(perr) - PDER_W'(pos_prev_error[wheel]);
      S_P_CLAMP: vt <= OUT_W'(clamp_sym(acc, {1'b0, pos_limit}));
      S_V_ERR: verr <= VERR_W'(vt) - VERR_W'(spd);
      S_V_INT: begin
        vint <= VERR_W'(clamp_sym(ACC_W'(vel_integral[wheel]) + ACC_W'(verr),
                                  vel_int_limit));
        vder <= VDER_W'(verr) - VDER_W'(vel_prev_error[wheel]);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_V_CLAMP && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_V_CLAMP && out_free) begin
      out_wheel <= wheel;
      out_vt    <= vt;
      out_drive <= OUT_W'(clamp_sym(acc, {1'b0, vel_limit}));
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.wheel_out       = out_wheel;
  assign out_ch.velocity_target = out_vt;
  assign out_ch.drive           = out_drive;

endmodule
`default_nettype wire
